// ===== rtl/ccu_pkg.sv =====
// Package for the combinatorics counting unit: widths, operation codes and
// the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ccu_pkg;

    // Width of n and k.
    localparam int N_WIDTH = 6;
    // Width of a result value (signed 64-bit range without the sign bit).
    localparam int VAL_W   = 63;
    // Width of one product acc * m, and of the dividend of the exact division.
    localparam int PROD_W  = VAL_W + N_WIDTH;
    // Width of the division step counter.
    localparam int BIT_W   = $clog2(PROD_W);

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_COMB = 2'd0,
        OP_PERM = 2'd1,
        OP_FACT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
        logic publish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iter_done;
        logic is_comb;
        logic div_last;
        logic prod_ovf;
    } t_dp_sts;

endpackage

// ===== rtl/ccu_if.sv =====
// Request and result channel interfaces of the combinatorics counting unit.
// Depends on ccu_pkg.
`timescale 1ns / 1ps

interface ccu_req_if import ccu_pkg::*; ();
    logic               valid;
    logic               ready;
    t_op                op;
    logic [N_WIDTH-1:0] n;
    logic [N_WIDTH-1:0] k;

    modport source (output valid, output op, output n, output k, input ready);
    modport sink   (input valid, input op, input n, input k, output ready);
endinterface

interface ccu_res_if import ccu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

// ===== rtl/ccu_dpath.sv =====
// Datapath of the combinatorics counting unit: operand registers, the
// accumulator, one multiplier and a bit-serial restoring divider.
// Depends on ccu_pkg.
`timescale 1ns / 1ps

module ccu_dpath import ccu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  t_op                i_op,
    input  logic [N_WIDTH-1:0] i_n,
    input  logic [N_WIDTH-1:0] i_k,
    output logic [VAL_W-1:0]   o_value,
    output logic               o_overflow
);

    logic               r_comb;
    logic [N_WIDTH-1:0] r_n;
    logic [N_WIDTH-1:0] r_cnt;
    logic [N_WIDTH-1:0] r_i;
    logic [VAL_W-1:0]   r_acc;
    logic               r_ovf;
    logic [PROD_W-1:0]  r_prod;
    logic [N_WIDTH-1:0] r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic [VAL_W-1:0]   r_value;
    logic               r_overflow;

    logic [N_WIDTH-1:0] w_cnt;
    logic               w_zero;
    logic [N_WIDTH-1:0] w_m;
    logic [N_WIDTH-1:0] w_d;
    logic [PROD_W-1:0]  w_prod;
    logic [N_WIDTH:0]   w_rem_sh;
    logic               w_ge;
    logic [N_WIDTH:0]   w_rem_sub;

    // Iteration count and empty-result decision for a new request. Factorial
    // is the falling product of n with itself; combinations use the smaller
    // of k and n-k.
    always_comb begin
        w_cnt  = '0;
        w_zero = 1'b0;
        case (i_op)
            OP_COMB: begin
                if (i_k > i_n) begin
                    w_zero = 1'b1;
                end else if (i_k > (i_n >> 1)) begin
                    w_cnt = i_n - i_k;
                end else begin
                    w_cnt = i_k;
                end
            end
            OP_PERM: begin
                if (i_k > i_n) begin
                    w_zero = 1'b1;
                end else begin
                    w_cnt = i_k;
                end
            end
            OP_FACT: begin
                w_cnt = i_n;
            end
            default: begin
                w_zero = 1'b1;
            end
        endcase
    end

    // Multiplier factor, divisor and the product of one iteration.
    assign w_m    = r_n - r_i;
    assign w_d    = r_i + N_WIDTH'(1);
    assign w_prod = r_acc * w_m;

    // One restoring division step on the top dividend bit.
    assign w_rem_sh  = {r_rem, r_prod[PROD_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_d});
    assign w_rem_sub = w_rem_sh - {1'b0, w_d};

    // Control registers: counters and the overflow mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i   <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_bit <= '0;
        end else begin
            if (i_cmd.load) begin
                r_i   <= '0;
                r_cnt <= w_cnt;
                r_ovf <= 1'b0;
            end
            if (i_cmd.mul) begin
                r_bit <= '0;
            end
            if (i_cmd.div_step) begin
                r_bit <= r_bit + BIT_W'(1);
            end
            if (i_cmd.commit) begin
                if (r_prod[PROD_W-1:VAL_W] != '0) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_i <= r_i + N_WIDTH'(1);
                end
            end
        end
    end

    // Payload registers: operands, accumulator, product and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_comb <= (i_op == OP_COMB);
            r_n    <= i_n;
            r_acc  <= w_zero ? '0 : VAL_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_rem_sub[N_WIDTH-1:0] : w_rem_sh[N_WIDTH-1:0];
            r_prod <= {r_prod[PROD_W-2:0], w_ge};
        end
        if (i_cmd.commit && (r_prod[PROD_W-1:VAL_W] == '0)) begin
            r_acc <= r_prod[VAL_W-1:0];
        end
        if (i_cmd.publish) begin
            r_value    <= r_ovf ? VAL_MAX : r_acc;
            r_overflow <= r_ovf;
        end
    end

    // Status towards the controller.
    assign o_sts.iter_done = (r_i == r_cnt);
    assign o_sts.is_comb   = r_comb;
    assign o_sts.div_last  = (r_bit == BIT_W'(PROD_W - 1));
    assign o_sts.prod_ovf  = (r_prod[PROD_W-1:VAL_W] != '0);

    assign o_value    = r_value;
    assign o_overflow = r_overflow;

    // The remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < w_d))
        else $error("division remainder reached the divisor");

    // The iteration index never passes the iteration count.
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load |-> (r_i <= r_cnt))
        else $error("iteration index beyond its count");

endmodule

// ===== rtl/ccu_ctrl.sv =====
// Controller of the combinatorics counting unit: sequences load, multiply,
// divide and commit steps and owns the handshake of both channels.
// Depends on ccu_pkg.
`timescale 1ns / 1ps

module ccu_ctrl import ccu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_MUL,
        S_DIV,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                n_state = i_sts.iter_done ? S_OUT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_sts.is_comb ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = i_sts.prod_ovf ? S_OUT : S_TEST;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result register stays full until its result is taken.
    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // A new result is written only into a free or draining result register.
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> w_slot_free)
        else $error("result written over a pending result");

    // An accepted request always starts work.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_TEST))
        else $error("accepted request did not start");

    // A commit is only reached after a multiply.
    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> ($past(r_state) == S_MUL || $past(r_state) == S_DIV))
        else $error("commit without a product");

endmodule

// ===== rtl/combinatorics_count_unit.sv =====
// Top level of the combinatorics counting unit: binds the controller and the
// datapath to the request and result channels.
// Depends on ccu_pkg, ccu_if, ccu_ctrl and ccu_dpath.
//
//   Channel   Direction  Payload                      Handshake
//   i_req     in         op (2), n (6), k (6)         valid / ready
//   o_res     out        value (63), overflow (1)     valid / ready
//
// One request is worked on at a time; the next is taken once the result
// sits in the output register, even while that result still waits.
// Combinations run k' = min(k, n-k) iterations of test, multiply, divide
// and commit steps; the bit-serial divider works one bit per cycle over the
// 69-bit product. Permutations and factorials run k (or n) iterations of
// test, multiply and commit steps. An early overflow ends the work at once.
// Reset is synchronous and active low and clears the controller state and
// the datapath counters; operand and result registers keep their contents.
`timescale 1ns / 1ps

module combinatorics_count_unit import ccu_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ccu_req_if.sink        i_req,
    ccu_res_if.source      o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    ccu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Arithmetic.
    ccu_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_op       (i_req.op),
        .i_n        (i_req.n),
        .i_k        (i_req.k),
        .o_value    (o_res.value),
        .o_overflow (o_res.overflow)
    );

endmodule

// ===== verif/combinatorics_count_unit_test.sv =====
// Self-checking testbench for combinatorics_count_unit: a directed table of
// requests, then random ones, each checked against a typed or modelled count.
// Depends on ccu_pkg, ccu_if and the combinatorics_count_unit RTL.
`timescale 1ns / 1ps

module combinatorics_count_unit_test;
    import ccu_pkg::*;

    localparam int          RANDOM_REQUESTS = 250;
    localparam int          CALM_TAIL       = 40;
    // Cycles allowed after the last result, about one worst-case combination.
    localparam int          SETTLE_CYCLES   = 2400;
    localparam int unsigned CYCLE_LIMIT     = 3_000_000;

    // One count as the result channel carries it.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             overflow;
    } t_count;

    // One row of the directed table; typed rows carry their count.
    typedef struct packed {
        t_op                op;
        logic [N_WIDTH-1:0] n;
        logic [N_WIDTH-1:0] k;
        logic               typed;
        t_count             count;
    } t_row;

    // A count still owed by the unit, with the request that caused it.
    typedef struct {
        t_op                op;
        logic [N_WIDTH-1:0] n;
        logic [N_WIDTH-1:0] k;
        t_count             count;
    } t_owed;

    localparam t_count ONE  = '{value: 63'd1, overflow: 1'b0};
    localparam t_count NIL  = '{value: 63'd0, overflow: 1'b0};
    localparam t_count SAT  = '{value: VAL_MAX, overflow: 1'b1};

    logic i_clk;
    logic i_rst_n;

    ccu_req_if req_ch ();
    ccu_res_if res_ch ();

    combinatorics_count_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Directed requests: edges of n and k, every op code, k above n,
    // the widest binomials and the first saturating products.
    t_row directed_rows [0:24] = '{
        '{OP_COMB, 6'd0,  6'd0,  1'b1, ONE},
        '{OP_COMB, 6'd63, 6'd0,  1'b1, ONE},
        '{OP_COMB, 6'd5,  6'd7,  1'b1, NIL},
        '{OP_COMB, 6'd0,  6'd63, 1'b1, NIL},
        '{OP_COMB, 6'd63, 6'd63, 1'b1, ONE},
        '{OP_COMB, 6'd1,  6'd1,  1'b1, ONE},
        '{OP_COMB, 6'd63, 6'd31, 1'b0, NIL},
        '{OP_COMB, 6'd63, 6'd32, 1'b0, NIL},
        '{OP_COMB, 6'd42, 6'd21, 1'b0, NIL},
        '{OP_PERM, 6'd0,  6'd0,  1'b1, ONE},
        '{OP_PERM, 6'd63, 6'd0,  1'b1, ONE},
        '{OP_PERM, 6'd3,  6'd4,  1'b1, NIL},
        '{OP_PERM, 6'd63, 6'd63, 1'b1, SAT},
        '{OP_PERM, 6'd21, 6'd21, 1'b1, SAT},
        '{OP_PERM, 6'd20, 6'd20, 1'b0, NIL},
        '{OP_PERM, 6'd63, 6'd10, 1'b0, NIL},
        '{OP_PERM, 6'd21, 6'd5,  1'b0, NIL},
        '{OP_FACT, 6'd0,  6'd63, 1'b1, ONE},
        '{OP_FACT, 6'd1,  6'd0,  1'b1, ONE},
        '{OP_FACT, 6'd20, 6'd0,  1'b0, NIL},
        '{OP_FACT, 6'd21, 6'd5,  1'b1, SAT},
        '{OP_FACT, 6'd63, 6'd63, 1'b1, SAT},
        '{OP_NONE, 6'd63, 6'd63, 1'b1, NIL},
        '{OP_NONE, 6'd0,  6'd0,  1'b1, NIL},
        '{OP_NONE, 6'd42, 6'd21, 1'b1, NIL}
    };

    t_owed       owed_counts [$];
    int unsigned mismatch_count;
    int unsigned op_tally [4];
    int unsigned saturated_seen;
    int unsigned cycle_count;
    bit          calm_tail;

    // Count for one request, worked out in 128 bits so that no partial
    // product can wrap before the saturation test sees it.
    function automatic t_count expected_count(input t_op op,
                                              input logic [N_WIDTH-1:0] n,
                                              input logic [N_WIDTH-1:0] k);
        logic [127:0] acc;
        logic [127:0] ceiling;
        int unsigned  nn;
        int unsigned  kk;
        int unsigned  i;
        bit           sat;
        t_count       res;
        acc     = 128'd1;
        ceiling = {65'd0, VAL_MAX};
        nn      = 32'(n);
        kk      = 32'(k);
        sat     = 1'b0;
        case (op)
            OP_COMB: begin
                if (kk > nn) begin
                    acc = 128'd0;
                end else begin
                    // The symmetric subset size keeps the loop short.
                    if (kk > nn / 2) kk = nn - kk;
                    for (i = 0; i < kk && !sat; i++) begin
                        acc = acc * (nn - i) / (i + 1);
                        if (acc > ceiling) sat = 1'b1;
                    end
                end
            end
            OP_PERM: begin
                if (kk > nn) begin
                    acc = 128'd0;
                end else begin
                    for (i = 0; i < kk && !sat; i++) begin
                        acc = acc * (nn - i);
                        if (acc > ceiling) sat = 1'b1;
                    end
                end
            end
            OP_FACT: begin
                for (i = 2; i <= nn && !sat; i++) begin
                    acc = acc * i;
                    if (acc > ceiling) sat = 1'b1;
                end
            end
            default: begin
                acc = 128'd0;
            end
        endcase
        res.value    = sat ? VAL_MAX : acc[VAL_W-1:0];
        res.overflow = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Presents one request, optionally after an idle burst, and records the
    // count it is owed once the unit has taken it.
    task automatic send_request(input t_op op, input logic [N_WIDTH-1:0] n,
                                input logic [N_WIDTH-1:0] k, input bit typed,
                                input t_count typed_count);
        t_owed entry;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.n     <= n;
        req_ch.k     <= k;
        do @(posedge i_clk); while (!req_ch.ready);
        entry.op    = op;
        entry.n     = n;
        entry.k     = k;
        entry.count = typed ? typed_count : expected_count(op, n, k);
        owed_counts.push_back(entry);
        op_tally[op]++;
    endtask

    // Holds the request side quiet until every owed count has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (owed_counts.size() != 0) @(posedge i_clk);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Reset and known levels on every input from the start.
    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_COMB;
        req_ch.n     <= '0;
        req_ch.k     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Cycle limit: a hung unit ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d counts still owed.",
                     cycle_count, owed_counts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stall bursts, none in the closing stretch.
    initial begin
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!calm_tail && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Each taken result is compared with the oldest owed count.
    always @(posedge i_clk) begin
        t_owed want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (owed_counts.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d with no request waiting",
                                          res_ch.value, res_ch.overflow));
            end else begin
                want = owed_counts.pop_front();
                if (res_ch.overflow) saturated_seen++;
                if (res_ch.value !== want.count.value)
                    report_mismatch($sformatf("%s n=%0d k=%0d: value %0d, wanted %0d",
                                              want.op.name(), want.n, want.k,
                                              res_ch.value, want.count.value));
                if (res_ch.overflow !== want.count.overflow)
                    report_mismatch($sformatf("%s n=%0d k=%0d: overflow %0b, wanted %0b",
                                              want.op.name(), want.n, want.k,
                                              res_ch.overflow, want.count.overflow));
            end
        end
    end

    // Request side: directed table, a full drain, then random requests.
    initial begin
        t_op                op;
        logic [N_WIDTH-1:0] n;
        logic [N_WIDTH-1:0] k;
        int                 pick;
        mismatch_count = 0;
        saturated_seen = 0;
        cycle_count    = 0;
        calm_tail      = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].n, directed_rows[r].k,
                         directed_rows[r].typed, directed_rows[r].count);
        drain_results();

        for (int idx = 0; idx < RANDOM_REQUESTS; idx++) begin
            if (idx == RANDOM_REQUESTS - CALM_TAIL) calm_tail = 1'b1;
            // The unused op code turns up now and then.
            pick = $urandom_range(0, 15);
            op   = (pick == 0) ? OP_NONE : t_op'(pick % 3);
            // Mostly small n keeps the long binomials rare.
            if ($urandom_range(0, 3) != 0) n = N_WIDTH'($urandom_range(0, 20));
            else                           n = N_WIDTH'($urandom_range(0, 63));
            // Mostly k within n; the rest anywhere, k above n included.
            if ($urandom_range(0, 6) != 0) k = N_WIDTH'($urandom_range(0, n));
            else                           k = N_WIDTH'($urandom_range(0, 63));
            send_request(op, n, k, 1'b0, NIL);
            if (idx % 60 == 59) drain_results();
        end
        req_ch.valid <= 1'b0;

        while (owed_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d combination, %0d permutation, %0d factorial and %0d unused-code",
                 op_tally[OP_COMB], op_tally[OP_PERM], op_tally[OP_FACT], op_tally[OP_NONE]);
        $display("requests; %0d results saturated, %0d mismatches in %0d cycles.",
                 saturated_seen, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
